// File: rtl/etmb_pkg.sv
package etmb_pkg;

   localparam int ANGLE_BITS_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int MAX_STEPS        = 24;
   localparam int ACC_W            = 36;
   localparam int PHASE_W          = 34;
   localparam logic signed [ACC_W-1:0] CORDIC_GAIN = 36'sd652032874;
   localparam logic signed [23:0] ENTRY_MAX = 24'sd8388607;
   localparam logic signed [23:0] ENTRY_MIN = -24'sd8388608;

   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [PHASE_W-1:0] phase_type;

   typedef struct packed {
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [31:0] move_z;
      logic signed [23:0] scale_x;
      logic signed [23:0] scale_y;
      logic signed [23:0] scale_z;
   } pass_type;

   typedef struct packed {
      acc_type x;
      acc_type y;
      phase_type z;
      logic neg;
   } rot_type;

   typedef struct packed {
      logic signed [23:0] m00;
      logic signed [23:0] m01;
      logic signed [23:0] m02;
      logic signed [31:0] m03;
      logic signed [23:0] m10;
      logic signed [23:0] m11;
      logic signed [23:0] m12;
      logic signed [31:0] m13;
      logic signed [23:0] m20;
      logic signed [23:0] m21;
      logic signed [23:0] m22;
      logic signed [31:0] m23;
   } matrix_type;

   function automatic logic signed [PHASE_W-1:0] atan_value(input int idx);
      logic signed [PHASE_W-1:0] t;
      case (idx)
         0: t = 34'sd536870912;
         1: t = 34'sd316933406;
         2: t = 34'sd167458907;
         3: t = 34'sd85004756;
         4: t = 34'sd42667331;
         5: t = 34'sd21354465;
         6: t = 34'sd10679838;
         7: t = 34'sd5340245;
         8: t = 34'sd2670163;
         9: t = 34'sd1335087;
         10: t = 34'sd667544;
         11: t = 34'sd333772;
         12: t = 34'sd166886;
         13: t = 34'sd83443;
         14: t = 34'sd41722;
         15: t = 34'sd20861;
         16: t = 34'sd10430;
         17: t = 34'sd5215;
         18: t = 34'sd2608;
         19: t = 34'sd1304;
         20: t = 34'sd652;
         21: t = 34'sd326;
         22: t = 34'sd163;
         23: t = 34'sd81;
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic signed [31:0] rnd30(input logic signed [71:0] v);
      logic signed [71:0] s;
      s = (v + 72'sd536870912) >>> 30;
      return s[31:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [71:0] v);
      logic signed [71:0] s;
      s = (v + 72'sd536870912) >>> 30;
      if (s > 72'sd8388607) return ENTRY_MAX;
      else if (s < -72'sd8388608) return ENTRY_MIN;
      else return s[23:0];
   endfunction

endpackage

// File: rtl/etmb_if.sv
interface etmb_req_if;
   import etmb_pkg::*;
   logic valid;
   logic ready;
   logic signed [31:0] move_x;
   logic signed [31:0] move_y;
   logic signed [31:0] move_z;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] heading_angle;
   logic signed [15:0] bank_angle;
   logic signed [23:0] scale_x;
   logic signed [23:0] scale_y;
   logic signed [23:0] scale_z;
   modport source (output valid, move_x, move_y, move_z, pitch_angle, heading_angle,
      bank_angle, scale_x, scale_y, scale_z, input ready);
   modport sink (input valid, move_x, move_y, move_z, pitch_angle, heading_angle,
      bank_angle, scale_x, scale_y, scale_z, output ready);
endinterface

interface etmb_rsp_if;
   import etmb_pkg::*;
   logic valid;
   logic ready;
   matrix_type m;
   modport source (output valid, m, input ready);
   modport sink (input valid, m, output ready);
endinterface

// File: rtl/etmb_cordic_cell.sv
module etmb_cordic_cell
   import etmb_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic    clock,
   input  logic    enable,
   input  rot_type rot_in [3],
   output rot_type rot_out [3]
);

   rot_type rot_out_ff [3];
   rot_type rot_out_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rot_out_in[k].neg = rot_in[k].neg;
         if (!rot_in[k].z[PHASE_W-1]) begin
            rot_out_in[k].x = rot_in[k].x - (rot_in[k].y >>> STEP);
            rot_out_in[k].y = rot_in[k].y + (rot_in[k].x >>> STEP);
            rot_out_in[k].z = rot_in[k].z - atan_value(STEP);
         end else begin
            rot_out_in[k].x = rot_in[k].x + (rot_in[k].y >>> STEP);
            rot_out_in[k].y = rot_in[k].y - (rot_in[k].x >>> STEP);
            rot_out_in[k].z = rot_in[k].z + atan_value(STEP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) rot_out_ff <= rot_out_in;
   end

   assign rot_out = rot_out_ff;

endmodule

// File: rtl/etmb_matrix_calc.sv
module etmb_matrix_calc
   import etmb_pkg::*;
(
   input  logic       clock,
   input  logic       enable,
   input  acc_type    sin_val [3],
   input  acc_type    cos_val [3],
   input  pass_type   pass_in,
   output matrix_type mat_out
);

   // Stage A: sp*sb, sp*cb, and the plain sines and cosines.
   logic signed [31:0] sp_ff, cp_ff, sh_ff, ch_ff, sb_ff, cb_ff;
   logic signed [31:0] spsb_ff, spcb_ff;
   pass_type pa_ff;
   // Stage B: pairwise products.
   logic signed [63:0] p_ff [12];
   logic signed [31:0] r5b_ff;
   pass_type pb_ff;
   // Stage C: rotation entries.
   logic signed [31:0] r_ff [9];
   pass_type pc_ff;
   // Stage D: scaling products.
   logic signed [71:0] q_ff [9];
   pass_type pd_ff;
   matrix_type mat_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         sp_ff <= sin_val[0][31:0];
         cp_ff <= cos_val[0][31:0];
         sh_ff <= sin_val[1][31:0];
         ch_ff <= cos_val[1][31:0];
         sb_ff <= sin_val[2][31:0];
         cb_ff <= cos_val[2][31:0];
         spsb_ff <= rnd30(72'($signed(sin_val[0][31:0]) * $signed(sin_val[2][31:0])));
         spcb_ff <= rnd30(72'($signed(sin_val[0][31:0]) * $signed(cos_val[2][31:0])));
         pa_ff <= pass_in;

         p_ff[0] <= ch_ff * cb_ff;
         p_ff[1] <= sh_ff * spsb_ff;
         p_ff[2] <= ch_ff * sb_ff;
         p_ff[3] <= sh_ff * spcb_ff;
         p_ff[4] <= sh_ff * cp_ff;
         p_ff[5] <= sb_ff * cp_ff;
         p_ff[6] <= cb_ff * cp_ff;
         p_ff[7] <= sh_ff * cb_ff;
         p_ff[8] <= ch_ff * spsb_ff;
         p_ff[9] <= sb_ff * sh_ff;
         p_ff[10] <= ch_ff * spcb_ff;
         p_ff[11] <= ch_ff * cp_ff;
         r5b_ff <= -sp_ff;
         pb_ff <= pa_ff;

         r_ff[0] <= rnd30(72'(p_ff[0]) + 72'(p_ff[1]));
         r_ff[1] <= rnd30(72'(p_ff[3]) - 72'(p_ff[2]));
         r_ff[2] <= rnd30(72'(p_ff[4]));
         r_ff[3] <= rnd30(72'(p_ff[5]));
         r_ff[4] <= rnd30(72'(p_ff[6]));
         r_ff[5] <= r5b_ff;
         r_ff[6] <= rnd30(72'(p_ff[8]) - 72'(p_ff[7]));
         r_ff[7] <= rnd30(72'(p_ff[9]) + 72'(p_ff[10]));
         r_ff[8] <= rnd30(72'(p_ff[11]));
         pc_ff <= pb_ff;

         for (int k = 0; k < 3; k++) begin
            q_ff[k*3+0] <= 72'(r_ff[k*3+0] * pc_ff.scale_x);
            q_ff[k*3+1] <= 72'(r_ff[k*3+1] * pc_ff.scale_y);
            q_ff[k*3+2] <= 72'(r_ff[k*3+2] * pc_ff.scale_z);
         end
         pd_ff <= pc_ff;

         mat_ff.m00 <= sat24(q_ff[0]);
         mat_ff.m01 <= sat24(q_ff[1]);
         mat_ff.m02 <= sat24(q_ff[2]);
         mat_ff.m03 <= pd_ff.move_x;
         mat_ff.m10 <= sat24(q_ff[3]);
         mat_ff.m11 <= sat24(q_ff[4]);
         mat_ff.m12 <= sat24(q_ff[5]);
         mat_ff.m13 <= pd_ff.move_y;
         mat_ff.m20 <= sat24(q_ff[6]);
         mat_ff.m21 <= sat24(q_ff[7]);
         mat_ff.m22 <= sat24(q_ff[8]);
         mat_ff.m23 <= pd_ff.move_z;
      end
   end

   assign mat_out = mat_ff;

endmodule

// File: rtl/euler_trs_matrix_builder.sv
// Euler-angle TRS matrix builder.
// The req channel carries one transaction per object: translation (Q16.16),
// pitch, heading and bank as binary angles (half scale equals pi) and three
// axis scales (Q8.16). The rsp channel returns the top three rows of the
// affine matrix T*R*S; the bottom row is always 0,0,0,1 and is not sent.
// Sines and cosines come from a chain of CORDIC_STEPS cells, one rotation
// step per cell, all three angles side by side. A five-stage multiplier
// pipeline then forms the rotation, applies the scales and saturates.
// Throughput is one transaction per cycle while the receiver does not stall,
// set by the fully unrolled chain.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting at the output, the chain holds and req ready drops only
// while the last stage is full and not being taken.
// Synchronous reset clears the valid bits of all stages; payload is not reset.
module euler_trs_matrix_builder
   import etmb_pkg::*;
#(
   parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input logic clock,
   input logic reset,
   etmb_req_if.sink   req,
   etmb_rsp_if.source rsp
);

   localparam int DEPTH = CORDIC_STEPS + 7;

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic             enable;

   assign enable    = !valid_ff[DEPTH-1] || rsp.ready;
   assign req.ready = enable;
   assign rsp.valid = valid_ff[DEPTH-1];

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (enable) valid_ff <= valid_in;
   end

   // Angle fold and chain entry.
   rot_type  rot_in [3];
   rot_type  rot_ff [3];
   rot_type  chain [CORDIC_STEPS+1][3];
   pass_type pass_ff [CORDIC_STEPS+2];
   logic signed [15:0] ang [3];

   assign ang[0] = req.pitch_angle;
   assign ang[1] = req.heading_angle;
   assign ang[2] = req.bank_angle;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [31:0] p;
         logic [31:0] raw;
         raw = 32'(unsigned'(ang[k][15:0]));
         p = (raw & ((32'd1 << ANGLE_BITS) - 32'd1)) << (32 - ANGLE_BITS);
         rot_in[k].neg = (p[31:30] == 2'b01) || (p[31:30] == 2'b10);
         if (rot_in[k].neg) p = p + 32'h8000_0000;
         rot_in[k].z = PHASE_W'(signed'(p));
         rot_in[k].x = CORDIC_GAIN;
         rot_in[k].y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rot_ff <= rot_in;
         pass_ff[0].move_x <= req.move_x;
         pass_ff[0].move_y <= req.move_y;
         pass_ff[0].move_z <= req.move_z;
         pass_ff[0].scale_x <= req.scale_x;
         pass_ff[0].scale_y <= req.scale_y;
         pass_ff[0].scale_z <= req.scale_z;
         for (int i = 1; i < CORDIC_STEPS + 2; i++) pass_ff[i] <= pass_ff[i-1];
      end
   end

   assign chain[0] = rot_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      etmb_cordic_cell #(.STEP(g)) u_cell (
         .clock   (clock),
         .enable  (enable),
         .rot_in  (chain[g]),
         .rot_out (chain[g+1])
      );
   end

   acc_type sin_ff [3];
   acc_type cos_ff [3];

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            sin_ff[k] <= chain[CORDIC_STEPS][k].neg ? -chain[CORDIC_STEPS][k].y
                                                    : chain[CORDIC_STEPS][k].y;
            cos_ff[k] <= chain[CORDIC_STEPS][k].neg ? -chain[CORDIC_STEPS][k].x
                                                    : chain[CORDIC_STEPS][k].x;
         end
      end
   end

   etmb_matrix_calc u_calc (
      .clock   (clock),
      .enable  (enable),
      .sin_val (sin_ff),
      .cos_val (cos_ff),
      .pass_in (pass_ff[CORDIC_STEPS+1]),
      .mat_out (rsp.m)
   );

endmodule
